// ----- rtl/core/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, operation and status codes, controller states and the
// circular address helper of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH    = 16;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OFF_W    = CNT_W + 1;
  localparam int SUM_W    = CNT_W + 2;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_DUMP       = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_DUMP,
    S_RESP
  } state_t;

  // Position of the element at a given offset from the front, modulo DEPTH.
  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                             input logic [OFF_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

endpackage

// ----- rtl/core/bdq_req_if.sv -----
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel that carries one operation and its operand word.
// ----------------------------------------------------------------------------
interface bdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::OP_W-1:0]          opcode;
  logic signed [bdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

// ----- rtl/core/bdq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Deque response channel
// Valid/ready channel that carries one result of an operation.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::STATUS_W-1:0]      status;
  logic signed [bdq_pkg::DATA_W-1:0] data;
  logic [bdq_pkg::COUNT_W-1:0]       count;
  logic                              last;

  modport source (output valid, output status, output data, output count, output last,
                  input ready);
  modport sink (input valid, input status, input data, input count, input last,
                output ready);
endinterface

// ----- rtl/core/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bounded_deque_with_delete.sv -----
// ----------------------------------------------------------------------------
// Bounded deque with delete by value
// Push and clear answer straight from execute; pop reads its element in a pop
// state first, delete scans for the value and shifts the later elements down
// over it, and dump walks the elements, one result per cycle while the output
// register can load. A new request is taken once the last result is loaded
// into the output register. The walk over the element RAM sets the delete and
// dump times. Reset empties the deque at once; the element RAM is not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete (
  input  logic      clk,
  input  logic      rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);
  import bdq_pkg::*;

  state_t              state, state_next;
  opcode_t             op;
  logic [DATA_W-1:0]   val;
  logic [ADDR_W-1:0]   head, head_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    idx, idx_next;
  status_t             resp_status, resp_status_next;
  logic [DATA_W-1:0]   resp_data, resp_data_next;

  logic                out_valid;
  status_t             out_status;
  logic [DATA_W-1:0]   out_data;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_wdata, mem_rdata;

  logic                can_load, out_load, dump_last;
  logic [OFF_W-1:0]    idx_p1, idx_p2, cnt_ext;
  logic [ADDR_W-1:0]   head_dec;
  logic                full, empty;

  assign idx_p1    = OFF_W'(idx) + OFF_W'(1);
  assign idx_p2    = OFF_W'(idx) + OFF_W'(2);
  assign cnt_ext   = OFF_W'(count);
  assign head_dec  = (head == '0) ? ADDR_W'(DEPTH - 1) : head - ADDR_W'(1);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign can_load  = !out_valid || rsp.ready;
  assign dump_last = (idx_p1 == cnt_ext);
  assign out_load  = can_load && (state == S_RESP || state == S_DUMP);

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;
  assign rsp.count  = out_count;
  assign rsp.last   = out_last;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    idx_next         = idx;
    resp_status_next = resp_status;
    resp_data_next   = resp_data;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        resp_status_next = ST_OK;
        resp_data_next   = '0;
        idx_next         = '0;
        state_next       = S_RESP;
        case (op) inside
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
              resp_status_next = ST_FULL;
            end else begin
              count_next = count + CNT_W'(1);
              if (op == OP_PUSH_FRONT) head_next = head_dec;
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) resp_status_next = ST_EMPTY;
            else state_next = S_POP;
          end
          OP_DELETE: begin
            if (empty) resp_status_next = ST_EMPTY;
            else state_next = S_SCAN;
          end
          OP_CLEAR: begin
            count_next = '0;
            head_next  = '0;
          end
          OP_DUMP: begin
            if (empty) resp_status_next = ST_EMPTY;
            else state_next = S_DUMP;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        resp_data_next = mem_rdata;
        count_next     = count - CNT_W'(1);
        if (op == OP_POP_FRONT) head_next = slot(head, OFF_W'(1));
        state_next = S_RESP;
      end
      S_SCAN: begin
        if (mem_rdata == val) begin
          if (idx_p1 == cnt_ext) begin
            count_next     = count - CNT_W'(1);
            resp_data_next = val;
            state_next     = S_RESP;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (idx_p1 == cnt_ext) begin
          resp_status_next = ST_NOT_FOUND;
          state_next       = S_RESP;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        if (idx_p2 == cnt_ext) begin
          count_next     = count - CNT_W'(1);
          resp_data_next = val;
          state_next     = S_RESP;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_DUMP: begin
        if (can_load) begin
          idx_next = idx + CNT_W'(1);
          if (dump_last) state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (can_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot(head, cnt_ext);
    mem_wdata = val;
    mem_raddr = head;
    unique case (state)
      S_EXEC: begin
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !full) begin
          mem_we    = 1'b1;
          mem_waddr = (op == OP_PUSH_FRONT) ? head_dec : slot(head, cnt_ext);
        end
        if (op == OP_POP_BACK) mem_raddr = slot(head, cnt_ext - OFF_W'(1));
      end
      S_SCAN: begin
        mem_raddr = slot(head, idx_p1);
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = slot(head, OFF_W'(idx));
        mem_wdata = mem_rdata;
        mem_raddr = slot(head, idx_p2);
      end
      S_DUMP: begin
        mem_raddr = can_load ? slot(head, idx_p1) : slot(head, OFF_W'(idx));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    resp_status <= resp_status_next;
    resp_data   <= resp_data_next;
    if (req.valid && req.ready) begin
      op  <= opcode_t'(req.opcode);
      val <= req.value;
    end
    if (out_load) begin
      out_count <= count_field(count);
      if (state == S_DUMP) begin
        out_status <= ST_OK;
        out_data   <= mem_rdata;
        out_last   <= dump_last;
      end else begin
        out_status <= resp_status;
        out_data   <= resp_data;
        out_last   <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("Element count exceeds the deque depth.");

  assert property (@(posedge clk) disable iff (rst) head <= ADDR_W'(DEPTH - 1))
    else $error("Head index is outside the element store.");

  assert property (@(posedge clk) disable iff (rst)
                   (state == S_SHIFT) |-> (mem_waddr != mem_raddr))
    else $error("Compaction reads the entry that it writes.");

  assert property (@(posedge clk) disable iff (rst)
                   (state == S_RESP && can_load) |=> (rsp.valid && rsp.last))
    else $error("Single result transaction is not marked last.");

endmodule
